// ----- hw/rtl/i2c_bus_monitor_defines.svh -----
// ----------------------------------------------------------------------------
// I2C bus monitor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_MONITOR_DEFINES_SVH
`define I2C_BUS_MONITOR_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor package
// Phase and event codes, sample and event records, default limits.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BYTE_LIMIT_DEF = 32;
  localparam int MAX_TRANS_DEF  = 16;
  localparam int BITS_PER_BYTE  = 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_ACK  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_START       = 3'd0,
    EV_ADDR_DONE   = 3'd1,
    EV_NACK        = 3'd2,
    EV_DATA        = 3'd3,
    EV_STOP_STORED = 3'd4,
    EV_STOP_FULL   = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [6:0]  target_address;
    logic        read_flag;
    logic [7:0]  data_value;
    logic [4:0]  byte_index;
    logic        byte_kept;
    logic [5:0]  byte_total;
    logic [31:0] begin_time;
    logic [4:0]  stored_total;
  } bus_event_t;

  typedef struct packed {
    logic advance;
  } stage_ctl_t;

endpackage

// ----- hw/rtl/i2cm_in_stage.sv -----
// ----------------------------------------------------------------------------
// I2C monitor sample register
// Captures one bus sample per request and holds it until the decoder advances.
// ----------------------------------------------------------------------------
module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_scl_level,
  input  logic        in_sda_level,
  input  logic [31:0] in_timestamp,
  input  logic        advance,
  output logic        item_valid,
  output sample_t     item
);

  logic    vld_r, vld_nxt;
  sample_t item_r;

  assign in_ready   = !vld_r || advance;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{scl_level: in_scl_level, sda_level: in_sda_level,
                  stamp: in_timestamp};
    end
  end

endmodule

// ----- hw/rtl/i2cm_decoder.sv -----
// ----------------------------------------------------------------------------
// I2C monitor protocol decoder
// Detects START/STOP and clock edges, tracks the transaction and forms events.
// ----------------------------------------------------------------------------
module i2cm_decoder
  import i2cm_pkg::*;
#(
  parameter int BYTE_LIMIT = BYTE_LIMIT_DEF,
  parameter int MAX_TRANS  = MAX_TRANS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  sample_t    item,
  output logic       has_event,
  output bus_event_t evt
);

  `include "i2c_bus_monitor_defines.svh"

  localparam int CNT_W = $clog2(BYTE_LIMIT + 1);
  localparam int STO_W = $clog2(MAX_TRANS + 1);

  phase_t           phase_r, phase_nxt;
  logic             prev_clk_r, prev_sda_r;
  logic [7:0]       shift_r, shift_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [6:0]       addr_r, addr_nxt;
  logic             rw_r, rw_nxt;
  logic [CNT_W-1:0] cnt_bytes_r, cnt_bytes_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic [STO_W-1:0] stored_r, stored_nxt;

  logic        start_c, stop_c, rise_c, last_bit;
  logic [7:0]  shift_in;
  event_kind_t kind;
  logic [7:0]  dval;
  logic [31:0] idx_ext, cnt_ext, sto_ext;
  logic        kept;

  assign start_c  = item.scl_level && prev_clk_r && !item.sda_level && prev_sda_r;
  assign stop_c   = item.scl_level && prev_clk_r && item.sda_level && !prev_sda_r;
  assign rise_c   = item.scl_level && !prev_clk_r;
  assign shift_in = {shift_r[6:0], item.sda_level};
  assign last_bit = (bit_cnt_r == 4'(BITS_PER_BYTE - 1));

  // phase transitions
  always_comb begin
    phase_nxt = phase_r;
    if (start_c) begin
      phase_nxt = PH_ADDR;
    end else if (stop_c) begin
      phase_nxt = PH_IDLE;
    end else if (rise_c) begin
      unique case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_ADDR: if (last_bit) phase_nxt = PH_ACK;
        PH_ACK:  phase_nxt = item.sda_level ? PH_IDLE : PH_DATA;
        PH_DATA: if (last_bit) phase_nxt = PH_ACK;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath updates and event selection
  always_comb begin
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    addr_nxt      = addr_r;
    rw_nxt        = rw_r;
    cnt_bytes_nxt = cnt_bytes_r;
    stamp_nxt     = stamp_r;
    stored_nxt    = stored_r;
    has_event     = 1'b0;
    kind          = EV_START;
    dval          = 8'd0;
    idx_ext       = 32'd0;
    kept          = 1'b0;
    if (start_c) begin
      shift_nxt     = 8'd0;
      bit_cnt_nxt   = 4'd0;
      addr_nxt      = 7'd0;
      rw_nxt        = 1'b0;
      cnt_bytes_nxt = '0;
      stamp_nxt     = item.stamp;
      has_event     = 1'b1;
      kind          = EV_START;
    end else if (stop_c) begin
      if (phase_r != PH_IDLE) begin
        has_event = 1'b1;
        if (stored_r < STO_W'(MAX_TRANS)) begin
          stored_nxt = stored_r + STO_W'(1);
          kind       = EV_STOP_STORED;
        end else begin
          kind       = EV_STOP_FULL;
        end
      end
    end else if (rise_c) begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_ADDR: begin
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (last_bit) begin
            addr_nxt    = shift_in[7:1];
            rw_nxt      = shift_in[0];
            bit_cnt_nxt = 4'd0;
            has_event   = 1'b1;
            kind        = EV_ADDR_DONE;
          end
        end
        PH_ACK: begin
          if (!item.sda_level) begin
            shift_nxt = 8'd0;
          end else begin
            has_event = 1'b1;
            kind      = EV_NACK;
          end
        end
        PH_DATA: begin
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (last_bit) begin
            dval        = shift_in;
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            has_event   = 1'b1;
            kind        = EV_DATA;
            // stop counting once the byte limit is reached; later bytes are not kept
            if (cnt_bytes_r < CNT_W'(BYTE_LIMIT)) begin
              idx_ext       = 32'(cnt_bytes_r);
              kept          = 1'b1;
              cnt_bytes_nxt = cnt_bytes_r + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = 32'(cnt_bytes_nxt);
  assign sto_ext = 32'(stored_nxt);

  always_comb begin
    evt.event_kind     = kind;
    evt.target_address = addr_nxt;
    evt.read_flag      = rw_nxt;
    evt.data_value     = dval;
    evt.byte_index     = idx_ext[4:0];
    evt.byte_kept      = kept;
    evt.byte_total     = cnt_ext[5:0];
    evt.begin_time     = stamp_nxt;
    evt.stored_total   = sto_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      prev_clk_r  <= 1'b1;
      prev_sda_r  <= 1'b1;
      shift_r     <= 8'd0;
      bit_cnt_r   <= 4'd0;
      addr_r      <= 7'd0;
      rw_r        <= 1'b0;
      cnt_bytes_r <= '0;
      stamp_r     <= 32'd0;
      stored_r    <= '0;
    end else if (ctl.advance) begin
      phase_r     <= phase_nxt;
      prev_clk_r  <= item.scl_level;
      prev_sda_r  <= item.sda_level;
      shift_r     <= shift_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      addr_r      <= addr_nxt;
      rw_r        <= rw_nxt;
      cnt_bytes_r <= cnt_bytes_nxt;
      stamp_r     <= stamp_nxt;
      stored_r    <= stored_nxt;
    end
  end

  `I2CM_ASSERT_NOW(a_cnt_limit, 1'b1, cnt_bytes_r <= CNT_W'(BYTE_LIMIT), "byte count over limit")
  `I2CM_ASSERT_NOW(a_bit_range, 1'b1, bit_cnt_r < 4'(BITS_PER_BYTE), "bit counter out of range")
  `I2CM_ASSERT_NEXT(a_start_addr, ctl.advance && start_c,
                    phase_r == PH_ADDR && bit_cnt_r == 4'd0, "start did not open address phase")
  `I2CM_ASSERT_NEXT(a_stored_mono, !ctl.advance,
                    $stable(stored_r) && $stable(phase_r), "state moved without a sample")

endmodule

// ----- hw/rtl/i2cm_out_stage.sv -----
// ----------------------------------------------------------------------------
// I2C monitor event register
// Holds one bus event until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cm_out_stage
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bus_event_t  evt,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [6:0]  out_target_address,
  output logic        out_read_flag,
  output logic [7:0]  out_data_value,
  output logic [4:0]  out_byte_index,
  output logic        out_byte_kept,
  output logic [5:0]  out_byte_total,
  output logic [31:0] out_begin_time,
  output logic [4:0]  out_stored_total
);

  logic       vld_r, vld_nxt;
  bus_event_t evt_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      evt_r <= evt;
    end
  end

  assign out_event_kind     = evt_r.event_kind;
  assign out_target_address = evt_r.target_address;
  assign out_read_flag      = evt_r.read_flag;
  assign out_data_value     = evt_r.data_value;
  assign out_byte_index     = evt_r.byte_index;
  assign out_byte_kept      = evt_r.byte_kept;
  assign out_byte_total     = evt_r.byte_total;
  assign out_begin_time     = evt_r.begin_time;
  assign out_stored_total   = evt_r.stored_total;

endmodule

// ----- hw/rtl/i2c_bus_monitor.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor
// Passive decoder of sampled SCL/SDA levels into START, address, data, NACK
// and STOP events.
// ----------------------------------------------------------------------------
// One bus sample is taken per clock cycle while in_ready is high. A sample
// is registered, decoded in a single pass against the bus state and, if it
// causes an event, written to the event register, so each event passes
// through the sample register and then the event register to out_valid.
// The event register lets the next sample in while an earlier event still
// waits; only a sample that produces an event while the event register is
// full and not being read holds in_ready low. The stored transaction count
// saturates at MAX_TRANS and data bytes beyond BYTE_LIMIT are reported as
// not kept.
module i2c_bus_monitor
  import i2cm_pkg::*;
#(
  parameter int BYTE_LIMIT = BYTE_LIMIT_DEF,
  parameter int MAX_TRANS  = MAX_TRANS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_scl_level,
  input  logic        in_sda_level,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [6:0]  out_target_address,
  output logic        out_read_flag,
  output logic [7:0]  out_data_value,
  output logic [4:0]  out_byte_index,
  output logic        out_byte_kept,
  output logic [5:0]  out_byte_total,
  output logic [31:0] out_begin_time,
  output logic [4:0]  out_stored_total
);

  stage_ctl_t ctl;
  sample_t    item;
  logic       item_valid;
  logic       has_event;
  logic       out_free;
  bus_event_t evt;

  // advance the sample unless its event has nowhere to go
  assign ctl.advance = item_valid && (!has_event || out_free);

  i2cm_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scl_level (in_scl_level),
    .in_sda_level (in_sda_level),
    .in_timestamp (in_timestamp),
    .advance      (ctl.advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  i2cm_decoder #(
    .BYTE_LIMIT (BYTE_LIMIT),
    .MAX_TRANS  (MAX_TRANS)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (item),
    .has_event (has_event),
    .evt       (evt)
  );

  i2cm_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (ctl.advance && has_event),
    .evt                (evt),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_target_address (out_target_address),
    .out_read_flag      (out_read_flag),
    .out_data_value     (out_data_value),
    .out_byte_index     (out_byte_index),
    .out_byte_kept      (out_byte_kept),
    .out_byte_total     (out_byte_total),
    .out_begin_time     (out_begin_time),
    .out_stored_total   (out_stored_total)
  );

endmodule

// ----- test/tb_i2c_bus_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus monitor testbench
// Drives sampled SCL/SDA levels with timestamps through the request channel,
// predicts every bus event in a local copy of the monitor state, and compares
// each event on the result channel field by field. A short directed table
// comes first, then well-formed transfers with random content mixed with
// noise and broken sequences, under random idling on both sides and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_i2c_bus_monitor;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 900;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_COUNT    = 25;

  typedef enum logic [1:0] {
    ROW_MODEL = 2'd0,
    ROW_TYPED = 2'd1,
    ROW_QUIET = 2'd2
  } row_mode_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic [31:0] stamp;
    row_mode_t   mode;
    bus_event_t  ev;
  } dir_row_t;

  localparam bus_event_t NO_EV = '0;

  // an idle sample, one short transfer, then a full address byte that is refused
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{1'b1, 1'b1, 32'h0000_0000, ROW_QUIET, NO_EV},
    '{1'b1, 1'b0, 32'h0000_0000, ROW_TYPED,
      '{EV_START, 7'h00, 1'b0, 8'h00, 5'd0, 1'b0, 6'd0, 32'h0000_0000, 5'd0}},
    '{1'b1, 1'b1, 32'hFFFF_FFFF, ROW_TYPED,
      '{EV_STOP_STORED, 7'h00, 1'b0, 8'h00, 5'd0, 1'b0, 6'd0, 32'h0000_0000, 5'd1}},
    '{1'b1, 1'b0, 32'hFFFF_FFFF, ROW_TYPED,
      '{EV_START, 7'h00, 1'b0, 8'h00, 5'd0, 1'b0, 6'd0, 32'hFFFF_FFFF, 5'd1}},
    '{1'b0, 1'b1, 32'h0000_0010, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0011, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_0012, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0013, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_0014, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0015, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_0016, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0017, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_0018, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0019, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_001A, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_001B, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_001C, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_001D, ROW_MODEL, NO_EV},
    '{1'b0, 1'b1, 32'h0000_001E, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_001F, ROW_TYPED,
      '{EV_ADDR_DONE, 7'h7F, 1'b1, 8'h00, 5'd0, 1'b0, 6'd0, 32'hFFFF_FFFF, 5'd1}},
    '{1'b0, 1'b1, 32'h0000_0020, ROW_MODEL, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0021, ROW_TYPED,
      '{EV_NACK, 7'h7F, 1'b1, 8'h00, 5'd0, 1'b0, 6'd0, 32'hFFFF_FFFF, 5'd1}},
    '{1'b0, 1'b0, 32'h0000_0022, ROW_QUIET, NO_EV},
    '{1'b1, 1'b0, 32'h0000_0023, ROW_QUIET, NO_EV},
    '{1'b1, 1'b1, 32'h0000_0024, ROW_QUIET, NO_EV}
  };

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_scl_level   = 1'b1;
  logic        in_sda_level   = 1'b1;
  logic [31:0] in_timestamp   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_event_kind;
  logic [6:0]  out_target_address;
  logic        out_read_flag;
  logic [7:0]  out_data_value;
  logic [4:0]  out_byte_index;
  logic        out_byte_kept;
  logic [5:0]  out_byte_total;
  logic [31:0] out_begin_time;
  logic [4:0]  out_stored_total;

  // local copy of the monitor state
  phase_t      mon_phase = PH_IDLE;
  logic        last_scl  = 1'b1;
  logic        last_sda  = 1'b1;
  logic [7:0]  shreg     = '0;
  logic [3:0]  bit_cnt   = '0;
  logic [6:0]  addr      = '0;
  logic        rw        = 1'b0;
  logic [5:0]  n_bytes   = '0;
  logic [31:0] t_start   = '0;
  logic [4:0]  n_stored  = '0;

  bus_event_t  pending_events[$];
  int          n_errors     = 0;
  int          n_sent       = 0;
  int          cycle_count  = 0;
  int          rx_cycle     = 0;
  bit          saw_full     = 1'b0;
  bit          saw_overflow = 1'b0;
  logic [31:0] stamp        = 32'h0000_0100;
  logic        drv_scl      = 1'b1;
  logic        drv_sda      = 1'b1;

  i2c_bus_monitor u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_scl_level      (in_scl_level),
    .in_sda_level      (in_sda_level),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_target_address(out_target_address),
    .out_read_flag     (out_read_flag),
    .out_data_value    (out_data_value),
    .out_byte_index    (out_byte_index),
    .out_byte_kept     (out_byte_kept),
    .out_byte_total    (out_byte_total),
    .out_begin_time    (out_begin_time),
    .out_stored_total  (out_stored_total)
  );

  always #1 clk = ~clk;

  task automatic decode_sample(input logic scl, input logic sda, input logic [31:0] t,
                               output bit fired, output bus_event_t ev);
    event_kind_t kind;
    logic [7:0]  dval;
    logic [4:0]  idx;
    logic        kept;
    fired = 1'b0;
    kind  = EV_START;
    dval  = '0;
    idx   = '0;
    kept  = 1'b0;
    if (scl && last_scl && !sda && last_sda) begin
      mon_phase = PH_ADDR;
      bit_cnt   = '0;
      shreg     = '0;
      t_start   = t;
      n_bytes   = '0;
      addr      = '0;
      rw        = 1'b0;
      fired     = 1'b1;
    end else if (scl && last_scl && sda && !last_sda) begin
      if (mon_phase != PH_IDLE) begin
        if (n_stored < 5'(MAX_TRANS_DEF)) begin
          n_stored = n_stored + 5'd1;
          kind     = EV_STOP_STORED;
        end else begin
          kind     = EV_STOP_FULL;
          saw_full = 1'b1;
        end
        mon_phase = PH_IDLE;
        fired     = 1'b1;
      end
    end else if (scl && !last_scl) begin
      case (mon_phase)
        PH_ADDR: begin
          shreg   = {shreg[6:0], sda};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt == 4'(BITS_PER_BYTE)) begin
            addr      = shreg[7:1];
            rw        = shreg[0];
            mon_phase = PH_ACK;
            bit_cnt   = '0;
            kind      = EV_ADDR_DONE;
            fired     = 1'b1;
          end
        end
        PH_ACK: begin
          // the acknowledge bit is not shifted in
          if (!sda) begin
            mon_phase = PH_DATA;
            shreg     = '0;
          end else begin
            mon_phase = PH_IDLE;
            kind      = EV_NACK;
            fired     = 1'b1;
          end
        end
        PH_DATA: begin
          shreg   = {shreg[6:0], sda};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt == 4'(BITS_PER_BYTE)) begin
            dval = shreg;
            if (n_bytes < 6'(BYTE_LIMIT_DEF)) begin
              idx     = n_bytes[4:0];
              kept    = 1'b1;
              n_bytes = n_bytes + 6'd1;
            end else begin
              saw_overflow = 1'b1;
            end
            mon_phase = PH_ACK;
            bit_cnt   = '0;
            shreg     = '0;
            kind      = EV_DATA;
            fired     = 1'b1;
          end
        end
        default: ;
      endcase
    end
    last_scl = scl;
    last_sda = sda;
    ev = '{kind, addr, rw, dval, idx, kept, n_bytes, t_start, n_stored};
  endtask

  // Present one sample; returns at the falling edge after it is accepted.
  task automatic send_sample(input logic scl, input logic sda, input logic [31:0] t,
                             output bit fired, output bus_event_t ev);
    while (!(n_sent >= 500 && n_sent < 800) && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_scl_level <= scl;
    in_sda_level <= sda;
    in_timestamp <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_sample(scl, sda, t, fired, ev);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic bus_drive(input logic scl, input logic sda);
    bit         fired;
    bus_event_t ev;
    if ($urandom_range(0, 49) == 0) stamp = $urandom();
    else stamp = stamp + $urandom_range(1, 20);
    send_sample(scl, sda, stamp, fired, ev);
    if (fired) pending_events.push_back(ev);
    drv_scl = scl;
    drv_sda = sda;
  endtask

  task automatic send_bit(input logic b);
    bus_drive(1'b0, b);
    bus_drive(1'b1, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  // pull SDA low with SCL high, first raising both lines if needed
  task automatic bus_start();
    if (!(drv_scl && drv_sda)) begin
      bus_drive(1'b0, 1'b1);
      bus_drive(1'b1, 1'b1);
    end
    bus_drive(1'b1, 1'b0);
  endtask

  task automatic bus_transaction(input int nbytes);
    bit nack;
    int tail;
    bus_start();
    send_byte({7'($urandom), 1'($urandom)});
    nack = (nbytes <= BYTE_LIMIT_DEF) && ($urandom_range(0, 9) == 0);
    send_bit(nack);
    for (int i = 0; i < nbytes && !nack; i++) begin
      send_byte(8'($urandom));
      nack = (nbytes <= BYTE_LIMIT_DEF) && ($urandom_range(0, 19) == 0);
      send_bit(nack);
    end
    tail = $urandom_range(0, 9);
    if (tail < 7) begin
      // raise SDA while SCL is high
      if (!(drv_scl && !drv_sda)) begin
        bus_drive(1'b0, 1'b0);
        bus_drive(1'b1, 1'b0);
      end
      bus_drive(1'b1, 1'b1);
    end
    // otherwise leave the bus as it is: repeated start or abandoned transfer
  endtask

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bus_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        n_errors++;
        $display("%0t: expected no event, got kind %0d", $time, out_event_kind);
      end else begin
        want = pending_events.pop_front();
        cmp_field("event_kind", 32'(want.event_kind), 32'(out_event_kind));
        cmp_field("target_address", 32'(want.target_address), 32'(out_target_address));
        cmp_field("read_flag", 32'(want.read_flag), 32'(out_read_flag));
        cmp_field("data_value", 32'(want.data_value), 32'(out_data_value));
        cmp_field("byte_index", 32'(want.byte_index), 32'(out_byte_index));
        cmp_field("byte_kept", 32'(want.byte_kept), 32'(out_byte_kept));
        cmp_field("byte_total", 32'(want.byte_total), 32'(out_byte_total));
        cmp_field("begin_time", want.begin_time, out_begin_time);
        cmp_field("stored_total", 32'(want.stored_total), 32'(out_stored_total));
      end
    end
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 400 && rx_cycle < 700) out_ready <= 1'b0;
      else if (rx_cycle >= 1500 && rx_cycle < 2100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit         fired;
    bus_event_t ev;
    int         pick;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      send_sample(DIR_ROWS[i].scl, DIR_ROWS[i].sda, DIR_ROWS[i].stamp, fired, ev);
      case (DIR_ROWS[i].mode)
        ROW_TYPED: pending_events.push_back(DIR_ROWS[i].ev);
        ROW_MODEL: if (fired) pending_events.push_back(ev);
        default: ;
      endcase
      drv_scl = DIR_ROWS[i].scl;
      drv_sda = DIR_ROWS[i].sda;
    end

    while (n_sent < ITEM_TARGET || !saw_full || !saw_overflow) begin
      pick = $urandom_range(0, 99);
      if (!saw_overflow && n_sent > 100) begin
        bus_transaction($urandom_range(BYTE_LIMIT_DEF + 1, BYTE_LIMIT_DEF + 3));
      end else if (pick < 30) begin
        bus_transaction(0);
      end else if (pick < 65) begin
        bus_transaction($urandom_range(1, 3));
      end else if (pick < 75) begin
        bus_transaction($urandom_range(4, 8));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) bus_drive(1'($urandom), 1'($urandom));
      end else begin
        // truncated transfer, usually cut by the next start
        bus_start();
        repeat ($urandom_range(1, 12)) send_bit(1'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_in_stage.sv
hw/rtl/i2cm_decoder.sv
hw/rtl/i2cm_out_stage.sv
hw/rtl/i2c_bus_monitor.sv
test/tb_i2c_bus_monitor.sv
